// ----- src/mpce_pkg.sv -----
// Shared types and constants for the mono pattern color expander.
// Used by every module of the block; depends on nothing else.
package mpce_pkg;

    localparam int COORD_BITS     = 10;
    localparam int DIM_BITS       = 11;
    localparam int POS_BITS       = 12;
    localparam int PAGE_BITS      = 2;
    localparam int CFG_COLOR_BITS = 16;
    localparam int ADDR_BITS      = 22;
    localparam int PAGE_DIM_BITS  = PAGE_BITS + DIM_BITS;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_FLIP_X     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FLIP_Y     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAGE       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PEN        = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_BACKGROUND = 3'd6;

    localparam logic [DIM_BITS-1:0]       WIDTH_RESET  = 11'd480;
    localparam logic [DIM_BITS-1:0]       HEIGHT_RESET = 11'd272;
    localparam logic [CFG_COLOR_BITS-1:0] PEN_RESET    = 16'hFFFF;

    typedef struct packed {
        logic                      flip_x;
        logic                      flip_y;
        logic [DIM_BITS-1:0]       width;
        logic [DIM_BITS-1:0]       height;
        logic [PAGE_BITS-1:0]      page;
        logic [CFG_COLOR_BITS-1:0] pen_color;
        logic [CFG_COLOR_BITS-1:0] background_color;
    } mpce_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic step;
    } mpce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic last_bit;
    } mpce_status_t;

endpackage

// ----- src/mono_pattern_color_expander_unit.sv -----
// Top level of the mono pattern color expander.
// Depends on mpce_pkg, mpce_regs, mpce_ctrl and mpce_dp.

// An item is taken at a clock edge where start is high and busy is low, and
// it expands into one result beat per used pattern bit, one beat a cycle.
// After the accept the block steps through the setup states MUL1, MUL2 and
// SUM for the row and page address (multiplies in MUL1 and MUL2, an add in
// SUM), then walks the pattern, and the next start is taken only once the
// walk is done; an item with a bit count of zero goes back to idle from MUL1
// and gives no beats. The first beat is registered by the first walk step.
// Result beats are shown for exactly one cycle on result_valid; there is no
// back-pressure, so the receiver must take every beat. Configuration writes
// are always ready and must be made only while the block is idle.
module mono_pattern_color_expander_unit
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int COLOR_BITS   = 16,
    parameter int PATTERN_BITS = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               opaque,
    input  logic [mpce_pkg::COORD_BITS-1:0]    start_x,
    input  logic [mpce_pkg::COORD_BITS-1:0]    start_y,
    input  logic [PATTERN_BITS-1:0]            pattern,
    input  logic [$clog2(PATTERN_BITS+1)-1:0]  bit_count,
    output logic                               result_valid,
    output logic [mpce_pkg::ADDR_BITS-1:0]     pixel_address,
    output logic [COLOR_BITS-1:0]              pixel_color,
    output logic                               write_enable,
    output logic                               outside,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpce_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mpce_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    mpce_pkg::mpce_cfg_t    cfg;
    mpce_pkg::mpce_cmd_t    cmd;
    mpce_pkg::mpce_status_t status;

    mpce_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpce_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    mpce_dp
    #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .COLOR_BITS   (COLOR_BITS),
        .PATTERN_BITS (PATTERN_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .opaque        (opaque),
        .start_x       (start_x),
        .start_y       (start_y),
        .pattern       (pattern),
        .bit_count     (bit_count),
        .result_valid  (result_valid),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .write_enable  (write_enable),
        .outside       (outside),
        .last          (last)
    );

endmodule

// ----- src/mpce_regs.sv -----
// Configuration register file of the mono pattern color expander.
// Depends on mpce_pkg for the register indexes and the config struct.
module mpce_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpce_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mpce_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output mpce_pkg::mpce_cfg_t                cfg
);

    mpce_pkg::mpce_cfg_t cfg_reg;
    mpce_pkg::mpce_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mpce_pkg::REG_FLIP_X:     cfg_next.flip_x = cfg_data[0];
                mpce_pkg::REG_FLIP_Y:     cfg_next.flip_y = cfg_data[0];
                mpce_pkg::REG_WIDTH:      cfg_next.width  = cfg_data[mpce_pkg::DIM_BITS-1:0];
                mpce_pkg::REG_HEIGHT:     cfg_next.height = cfg_data[mpce_pkg::DIM_BITS-1:0];
                mpce_pkg::REG_PAGE:       cfg_next.page   = cfg_data[mpce_pkg::PAGE_BITS-1:0];
                mpce_pkg::REG_PEN:        cfg_next.pen_color = cfg_data;
                mpce_pkg::REG_BACKGROUND: cfg_next.background_color = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flip_x           <= 1'b0;
            cfg_reg.flip_y           <= 1'b0;
            cfg_reg.width            <= mpce_pkg::WIDTH_RESET;
            cfg_reg.height           <= mpce_pkg::HEIGHT_RESET;
            cfg_reg.page             <= '0;
            cfg_reg.pen_color        <= mpce_pkg::PEN_RESET;
            cfg_reg.background_color <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/mpce_ctrl.sv -----
// Sequencing controller of the mono pattern color expander.
// Depends on mpce_pkg for the command and status structs.
module mpce_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output mpce_pkg::mpce_cmd_t    cmd,
    input  mpce_pkg::mpce_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = status.empty ? S_IDLE : S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_bit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN && status.last_bit |=> state_reg == S_IDLE)
        else $error("controller did not return to idle after the final bit");

endmodule

// ----- src/mpce_dp.sv -----
// Datapath of the mono pattern color expander: address setup and pixel walk.
// Depends on mpce_pkg for widths, the config struct and the command and status structs.
module mpce_dp
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int COLOR_BITS   = 16,
    parameter int PATTERN_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mpce_pkg::mpce_cfg_t                  cfg,
    input  mpce_pkg::mpce_cmd_t                  cmd,
    output mpce_pkg::mpce_status_t               status,
    input  logic                                 opaque,
    input  logic [mpce_pkg::COORD_BITS-1:0]      start_x,
    input  logic [mpce_pkg::COORD_BITS-1:0]      start_y,
    input  logic [PATTERN_BITS-1:0]              pattern,
    input  logic [$clog2(PATTERN_BITS+1)-1:0]    bit_count,
    output logic                                 result_valid,
    output logic [mpce_pkg::ADDR_BITS-1:0]       pixel_address,
    output logic [COLOR_BITS-1:0]                pixel_color,
    output logic                                 write_enable,
    output logic                                 outside,
    output logic                                 last
);

    localparam int CNT_BITS = $clog2(PATTERN_BITS + 1);
    localparam int DW       = mpce_pkg::DIM_BITS;
    localparam int PW       = mpce_pkg::POS_BITS;
    localparam int AW       = mpce_pkg::ADDR_BITS;

    logic [31:0]             max_w;
    logic [31:0]             max_h;
    logic [DW-1:0]           w_eff;
    logic [DW-1:0]           h_eff;
    logic [CNT_BITS-1:0]     cnt_sat;
    logic [PW-1:0]           row_start;
    logic [PW-1:0]           col_start;
    logic [DW+DW+1:0]        base_full;
    logic                    col_out;
    logic                    pix_out;
    logic [31:0]             pen32;
    logic [31:0]             bg32;

    logic                    opaque_reg;
    logic                    dir_left_reg;
    logic [PATTERN_BITS-1:0] pat_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [DW-1:0]           w_reg;
    logic [DW-1:0]           h_reg;
    logic [PW-1:0]           row_reg;
    logic [PW-1:0]           col_reg;
    logic                    row_out_reg;
    logic [mpce_pkg::PAGE_DIM_BITS-1:0] pw_reg;
    logic [AW-1:0]           roww_reg;
    logic [AW-1:0]           base_reg;
    logic [AW-1:0]           line_reg;

    logic                    result_valid_reg;
    logic [AW-1:0]           pixel_address_reg;
    logic [COLOR_BITS-1:0]   pixel_color_reg;
    logic                    write_enable_reg;
    logic                    outside_reg;
    logic                    last_reg;

    assign max_w = 32'(MAX_WIDTH);
    assign max_h = 32'(MAX_HEIGHT);
    assign w_eff = (32'(cfg.width) > max_w) ? max_w[DW-1:0] : cfg.width;
    assign h_eff = (32'(cfg.height) > max_h) ? max_h[DW-1:0] : cfg.height;
    assign cnt_sat = (bit_count > CNT_BITS'(PATTERN_BITS)) ? CNT_BITS'(PATTERN_BITS)
                                                           : bit_count;

    // Positions are two's complement; a mirrored start can fall below zero.
    assign row_start = cfg.flip_y ? (PW'(h_eff) - PW'(1) - PW'(start_y)) : PW'(start_y);
    assign col_start = cfg.flip_x ? (PW'(w_eff) - PW'(1) - PW'(start_x)) : PW'(start_x);

    assign base_full = (DW+DW+2)'(pw_reg) * (DW+DW+2)'(h_reg);

    assign col_out = col_reg[PW-1] || (col_reg[DW-1:0] >= w_reg);
    assign pix_out = col_out || row_out_reg;
    assign pen32   = 32'(cfg.pen_color);
    assign bg32    = 32'(cfg.background_color);

    assign status.empty    = (cnt_reg == '0);
    assign status.last_bit = (cnt_reg == CNT_BITS'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opaque_reg   <= opaque;
            dir_left_reg <= cfg.flip_x;
            pat_reg      <= pattern;
            cnt_reg      <= cnt_sat;
            w_reg        <= w_eff;
            h_reg        <= h_eff;
            row_reg      <= row_start;
            col_reg      <= col_start;
        end
        if (cmd.mul1)
        begin
            pw_reg      <= mpce_pkg::PAGE_DIM_BITS'(cfg.page)
                           * mpce_pkg::PAGE_DIM_BITS'(w_reg);
            roww_reg    <= AW'(row_reg[DW-1:0]) * AW'(w_reg);
            row_out_reg <= row_reg[PW-1] || (row_reg[DW-1:0] >= h_reg);
        end
        if (cmd.mul2)
        begin
            base_reg <= base_full[AW-1:0];
        end
        if (cmd.sum)
        begin
            line_reg <= base_reg + roww_reg;
        end
        if (cmd.step)
        begin
            col_reg <= dir_left_reg ? (col_reg - PW'(1)) : (col_reg + PW'(1));
            pat_reg <= {pat_reg[PATTERN_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_BITS'(1);

            last_reg <= (cnt_reg == CNT_BITS'(1));
            if (pix_out)
            begin
                pixel_address_reg <= '0;
                pixel_color_reg   <= '0;
                write_enable_reg  <= 1'b0;
                outside_reg       <= 1'b1;
            end
            else
            begin
                pixel_address_reg <= line_reg + AW'(col_reg[DW-1:0]);
                outside_reg       <= 1'b0;
                if (pat_reg[PATTERN_BITS-1])
                begin
                    pixel_color_reg  <= pen32[COLOR_BITS-1:0];
                    write_enable_reg <= 1'b1;
                end
                else if (opaque_reg)
                begin
                    pixel_color_reg  <= bg32[COLOR_BITS-1:0];
                    write_enable_reg <= 1'b1;
                end
                else
                begin
                    pixel_color_reg  <= '0;
                    write_enable_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.step;
        end
    end

    assign result_valid  = result_valid_reg;
    assign pixel_address = pixel_address_reg;
    assign pixel_color   = pixel_color_reg;
    assign write_enable  = write_enable_reg;
    assign outside       = outside_reg;
    assign last          = last_reg;

    a_outside_blank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && outside |-> !write_enable && pixel_address == '0
                                    && pixel_color == '0)
        else $error("pixel outside the window carries a write or data");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result beat directly follows the final beat of a run");

endmodule

// ----- tb/sv/mono_pattern_color_expander_unit_tb.sv -----
// Self-checking testbench for mono_pattern_color_expander_unit.
// It drives directed and random pattern runs, predicts every pixel beat and
// compares each one. Depends on mpce_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module mono_pattern_color_expander_unit_tb;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int RUN_BITS     = 32;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_RUNS   = 30;
    localparam int NUM_PHASES   = 6;
    localparam int SETTLE_TICKS = 8;

    typedef struct packed {
        logic                            opq;
        logic [mpce_pkg::COORD_BITS-1:0] x;
        logic [mpce_pkg::COORD_BITS-1:0] y;
        logic [RUN_BITS-1:0]             pat;
        logic [5:0]                      cnt;
    } run_t;

    typedef struct packed {
        logic [mpce_pkg::ADDR_BITS-1:0]      addr;
        logic [mpce_pkg::CFG_COLOR_BITS-1:0] color;
        logic                                we;
        logic                                outside;
        logic                                last;
    } pixel_t;

    typedef struct packed {
        run_t   run;
        logic   typed;
        pixel_t px;
    } run_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic                                opaque;
    logic [mpce_pkg::COORD_BITS-1:0]     start_x;
    logic [mpce_pkg::COORD_BITS-1:0]     start_y;
    logic [RUN_BITS-1:0]                 pattern;
    logic [5:0]                          bit_count;
    logic                                result_valid;
    logic [mpce_pkg::ADDR_BITS-1:0]      pixel_address;
    logic [mpce_pkg::CFG_COLOR_BITS-1:0] pixel_color;
    logic                                write_enable;
    logic                                outside;
    logic                                last;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [mpce_pkg::CFG_IDX_BITS-1:0]   cfg_index;
    logic [mpce_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    mpce_pkg::mpce_cfg_t shadow;
    pixel_t    pixel_queue [$];
    pixel_t    want;
    logic      run_typed;
    pixel_t    run_typed_px;
    int        fails;
    int        cycles;

    // Runs under the reset window (480 x 272); the typed rows are single-pixel and carry their beat.
    run_row_t directed_rows [18] = '{
        '{'{1'b0, 10'd0,   10'd0,   32'h8000_0000, 6'd1},  1'b1,
          '{22'd0,      16'hFFFF, 1'b1, 1'b0, 1'b1}},
        '{'{1'b0, 10'd479, 10'd271, 32'hFFFF_FFFF, 6'd1},  1'b1,
          '{22'd130559, 16'hFFFF, 1'b1, 1'b0, 1'b1}},
        '{'{1'b0, 10'd480, 10'd0,   32'hFFFF_FFFF, 6'd1},  1'b1,
          '{22'd0,      16'h0000, 1'b0, 1'b1, 1'b1}},
        '{'{1'b0, 10'd0,   10'd272, 32'hFFFF_FFFF, 6'd1},  1'b1,
          '{22'd0,      16'h0000, 1'b0, 1'b1, 1'b1}},
        '{'{1'b0, 10'd1023, 10'd1023, 32'h0000_0000, 6'd1}, 1'b1,
          '{22'd0,      16'h0000, 1'b0, 1'b1, 1'b1}},
        '{'{1'b0, 10'd5,   10'd1,   32'h0000_0000, 6'd1},  1'b1,
          '{22'd485,    16'h0000, 1'b0, 1'b0, 1'b1}},
        '{'{1'b1, 10'd5,   10'd1,   32'h7FFF_FFFF, 6'd1},  1'b1,
          '{22'd485,    16'h0000, 1'b1, 1'b0, 1'b1}},
        '{'{1'b1, 10'd10,  10'd10,  32'hFFFF_FFFF, 6'd0},  1'b0, '0},
        '{'{1'b1, 10'd100, 10'd50,  32'hAAAA_5555, 6'd32}, 1'b0, '0},
        '{'{1'b0, 10'd100, 10'd50,  32'h5555_AAAA, 6'd32}, 1'b0, '0},
        '{'{1'b1, 10'd0,   10'd0,   32'hFFFF_0000, 6'd33}, 1'b0, '0},
        '{'{1'b0, 10'd200, 10'd100, 32'h0F0F_0F0F, 6'd63}, 1'b0, '0},
        '{'{1'b1, 10'd460, 10'd271, 32'h1234_5678, 6'd32}, 1'b0, '0},
        '{'{1'b0, 10'd1023, 10'd0,  32'hFFFF_FFFF, 6'd32}, 1'b0, '0},
        '{'{1'b1, 10'h2AA, 10'h155, 32'hDEAD_BEEF, 6'd32}, 1'b0, '0},
        '{'{1'b0, 10'h155, 10'h2AA, 32'hC3C3_3C3C, 6'd16}, 1'b0, '0},
        '{'{1'b1, 10'h155, 10'h0AA, 32'h8421_0842, 6'd31}, 1'b0, '0},
        '{'{1'b1, 10'd479, 10'd0,   32'h0000_0000, 6'd1},  1'b0, '0}
    };

    mono_pattern_color_expander_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opaque        (opaque),
        .start_x       (start_x),
        .start_y       (start_y),
        .pattern       (pattern),
        .bit_count     (bit_count),
        .result_valid  (result_valid),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .write_enable  (write_enable),
        .outside       (outside),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expands one run into the pixel beats it should produce.
    function automatic void expand_run(input run_t r);
        longint w;
        longint h;
        longint xs;
        longint row;
        longint col;
        longint addr;
        int     n;
        pixel_t px;
        w   = (shadow.width > MAX_WIDTH) ? MAX_WIDTH : shadow.width;
        h   = (shadow.height > MAX_HEIGHT) ? MAX_HEIGHT : shadow.height;
        xs  = r.x;
        row = r.y;
        n   = (r.cnt > RUN_BITS) ? RUN_BITS : r.cnt;
        if (shadow.flip_y)
        begin
            row = h - 1 - row;
        end
        for (int i = 0; i < n; i++)
        begin
            col = shadow.flip_x ? (w - 1 - xs - i) : (xs + i);
            px  = '0;
            if (col < 0 || col >= w || row < 0 || row >= h)
            begin
                px.outside = 1'b1;
            end
            else
            begin
                addr    = longint'(shadow.page) * w * h + row * w + col;
                px.addr = addr[mpce_pkg::ADDR_BITS-1:0];
                if (r.pat[RUN_BITS-1-i])
                begin
                    px.color = shadow.pen_color;
                    px.we    = 1'b1;
                end
                else if (r.opq)
                begin
                    px.color = shadow.background_color;
                    px.we    = 1'b1;
                end
            end
            px.last = (i == n - 1);
            pixel_queue.push_back(px);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fails++;
        end
    endfunction

    // Results are checked before the newly accepted run is predicted, so a
    // beat and an accept on the same edge cannot disturb the queue order.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pixel_queue.size() == 0)
            begin
                $error("pixel beat with no expectation pending: address 0x%0h",
                       pixel_address);
                fails++;
            end
            else
            begin
                want = pixel_queue.pop_front();
                compare_field("pixel_address", 32'(want.addr), 32'(pixel_address));
                compare_field("pixel_color", 32'(want.color), 32'(pixel_color));
                compare_field("write_enable", 32'(want.we), 32'(write_enable));
                compare_field("outside", 32'(want.outside), 32'(outside));
                compare_field("last", 32'(want.last), 32'(last));
            end
        end
        if (rst_n && start && !busy)
        begin
            if (run_typed)
            begin
                pixel_queue.push_back(run_typed_px);
            end
            else
            begin
                expand_run(run_t'{opaque, start_x, start_y, pattern, bit_count});
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_run(input run_t r, input logic typed, input pixel_t px,
                            input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        opaque       <= r.opq;
        start_x      <= r.x;
        start_y      <= r.y;
        pattern      <= r.pat;
        bit_count    <= r.cnt;
        run_typed    = typed;
        run_typed_px = px;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Waits until every expected beat is in, plus the tail of a zero-length run.
    task automatic settle();
        start <= 1'b0;
        while (pixel_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic program_window(input logic [15:0] fx, input logic [15:0] fy,
                                  input logic [15:0] wd, input logic [15:0] ht,
                                  input logic [15:0] pg, input logic [15:0] pen,
                                  input logic [15:0] bg);
        logic [15:0] words [7];
        words[mpce_pkg::REG_FLIP_X]     = fx;
        words[mpce_pkg::REG_FLIP_Y]     = fy;
        words[mpce_pkg::REG_WIDTH]      = wd;
        words[mpce_pkg::REG_HEIGHT]     = ht;
        words[mpce_pkg::REG_PAGE]       = pg;
        words[mpce_pkg::REG_PEN]        = pen;
        words[mpce_pkg::REG_BACKGROUND] = bg;
        for (int i = 0; i < 7; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= mpce_pkg::CFG_IDX_BITS'(i);
            cfg_data  <= words[i];
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            case (mpce_pkg::CFG_IDX_BITS'(i))
                mpce_pkg::REG_FLIP_X:     shadow.flip_x = words[i][0];
                mpce_pkg::REG_FLIP_Y:     shadow.flip_y = words[i][0];
                mpce_pkg::REG_WIDTH:      shadow.width  = words[i][mpce_pkg::DIM_BITS-1:0];
                mpce_pkg::REG_HEIGHT:     shadow.height = words[i][mpce_pkg::DIM_BITS-1:0];
                mpce_pkg::REG_PAGE:       shadow.page   = words[i][mpce_pkg::PAGE_BITS-1:0];
                mpce_pkg::REG_PEN:        shadow.pen_color        = words[i];
                mpce_pkg::REG_BACKGROUND: shadow.background_color = words[i];
                default:                  ;
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Most runs start in or just past the window so that pixels get drawn.
    function automatic run_t random_run();
        run_t r;
        int   w;
        int   h;
        int   pick;
        w     = (shadow.width > MAX_WIDTH) ? MAX_WIDTH : shadow.width;
        h     = (shadow.height > MAX_HEIGHT) ? MAX_HEIGHT : shadow.height;
        r.opq = 1'($urandom_range(0, 1));
        r.pat = $urandom();
        r.x   = ($urandom_range(0, 3) != 0)
                ? 10'($urandom_range(0, (w + 4 > 1023) ? 1023 : w + 4))
                : 10'($urandom_range(0, 1023));
        r.y   = ($urandom_range(0, 3) != 0)
                ? 10'($urandom_range(0, (h + 2 > 1023) ? 1023 : h + 2))
                : 10'($urandom_range(0, 1023));
        pick  = $urandom_range(0, 19);
        if (pick == 0)
        begin
            r.cnt = 6'd0;
        end
        else if (pick == 1)
        begin
            r.cnt = 6'($urandom_range(33, 63));
        end
        else if (pick < 5)
        begin
            r.cnt = 6'd32;
        end
        else
        begin
            r.cnt = 6'($urandom_range(1, 31));
        end
        return r;
    endfunction

    initial
    begin
        int idle_pct [3];
        idle_pct[0] = 11;
        idle_pct[1] = 87;
        idle_pct[2] = 0;
        fails     = 0;
        cycles    = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        opaque    = 1'b0;
        start_x   = '0;
        start_y   = '0;
        pattern   = '0;
        bit_count = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        run_typed = 1'b0;
        run_typed_px            = '0;
        shadow.flip_x           = 1'b0;
        shadow.flip_y           = 1'b0;
        shadow.width            = mpce_pkg::WIDTH_RESET;
        shadow.height           = mpce_pkg::HEIGHT_RESET;
        shadow.page             = '0;
        shadow.pen_color        = mpce_pkg::PEN_RESET;
        shadow.background_color = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
        begin
            send_run(directed_rows[k].run, directed_rows[k].typed, directed_rows[k].px, 11);
        end
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                // Largest window on the top page: addresses reach the top of
                // the 22-bit range.
                0: program_window(16'd1, 16'd0, 16'd1024, 16'd1024, 16'd3,
                                  16'($urandom()), 16'($urandom()));
                1: program_window(16'd0, 16'd1, 16'd1, 16'd1, 16'd1,
                                  16'($urandom()), 16'($urandom()));
                // Zero width: every pixel falls outside.
                2: program_window(16'hFFFF, 16'hFFFF, 16'd0, 16'd7, 16'd2,
                                  16'($urandom()), 16'($urandom()));
                // Oversized window, clamped to the maximum; upper data bits set.
                3: program_window(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'd2000, 16'hFFFE,
                                  16'h0000, 16'hFFFF);
                4: program_window(16'd0, 16'd1, 16'hF828, 16'd0, 16'd0,
                                  16'($urandom()), 16'($urandom()));
                default: program_window(16'($urandom()), 16'($urandom()),
                                        16'($urandom_range(1, 1024)),
                                        16'($urandom_range(1, 1024)), 16'($urandom()),
                                        16'($urandom()), 16'($urandom()));
            endcase
            for (int n = 0; n < PHASE_RUNS; n++)
            begin
                send_run(random_run(), 1'b0, '0, idle_pct[phase / 2]);
            end
            settle();
        end

        if (fails == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
